/* rtl/color_palette_learn_and_match_core_macros.svh */
// assertion macros shared by the checker
`ifndef COLOR_PALETTE_LEARN_AND_MATCH_CORE_MACROS_SVH
`define COLOR_PALETTE_LEARN_AND_MATCH_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define CPLM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cplm assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define CPLM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cplm assertion failed");

`endif

/* rtl/cplm_pkg.sv */
package cplm_pkg;

  // field widths
  localparam int unsigned ColorW   = 24;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned LimitW   = 10;
  localparam int unsigned LimitSqW = 20;
  localparam int unsigned CountW   = 5;

  // redmean weights and register reset
  localparam logic [9:0]          RedBase    = 10'd512;
  localparam logic [9:0]          BlueBase   = 10'd767;
  localparam logic [LimitW-1:0]   LimitReset = 10'd30;
  localparam logic [LimitSqW-1:0] LimitSqReset = LimitSqW'(30 * 30);

  // operation codes
  localparam logic OpLearn = 1'b0;
  localparam logic OpMatch = 1'b1;

  // input item
  typedef struct packed {
    logic              operation;
    logic [ColorW-1:0] pixel_color;
    logic              batch_start;
  } cplm_in_t;

  // result item
  typedef struct packed {
    logic              matched;
    logic              added;
    logic              palette_full;
    logic [CountW-1:0] entry_count;
  } cplm_out_t;

  // token walking along the cell row
  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] color;
    logic              hit;
  } cplm_tok_t;

  // absolute difference of two channel values
  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/cplm_cell.sv */
module cplm_cell import cplm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cplm_tok_t           tok_i,
  output cplm_tok_t           tok_o,
  input  logic                en_i,
  input  logic                wr_en_i,
  input  logic [ColorW-1:0]   wr_color_i,
  input  logic [LimitSqW-1:0] limit_sq_i
);

  logic [ColorW-1:0] entry_q;

  // first stage: channel squares and red mean
  cplm_tok_t    s1_tok_q;
  logic [7:0]   rmean_d, rmean_q;
  logic [15:0]  dr2_d, dg2_d, db2_d;
  logic [15:0]  dr2_q, dg2_q, db2_q;
  logic [7:0]   dr, dg, db;

  // second stage: weighted sum and compare
  logic [9:0]   wr, wb;
  logic [25:0]  pr, pb;
  logic [19:0]  dist_sum;
  logic         near;
  cplm_tok_t    tok_d, tok_q;

  // stored palette entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_color_i;
    end
  end

  always_comb begin
    dr      = abs_diff(tok_i.color[23:16], entry_q[23:16]);
    dg      = abs_diff(tok_i.color[15:8], entry_q[15:8]);
    db      = abs_diff(tok_i.color[7:0], entry_q[7:0]);
    rmean_d = 8'(({1'b0, tok_i.color[23:16]} + {1'b0, entry_q[23:16]}) >> 1);
    dr2_d   = {8'd0, dr} * {8'd0, dr};
    dg2_d   = {8'd0, dg} * {8'd0, dg};
    db2_d   = {8'd0, db} * {8'd0, db};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tok_q <= '0;
      rmean_q  <= '0;
      dr2_q    <= '0;
      dg2_q    <= '0;
      db2_q    <= '0;
    end else begin
      s1_tok_q <= tok_i;
      rmean_q  <= rmean_d;
      dr2_q    <= dr2_d;
      dg2_q    <= dg2_d;
      db2_q    <= db2_d;
    end
  end

  // redmean distance against limit squared
  always_comb begin
    wr       = RedBase + {2'd0, rmean_q};
    wb       = BlueBase - {2'd0, rmean_q};
    pr       = {16'd0, wr} * {10'd0, dr2_q};
    pb       = {16'd0, wb} * {10'd0, db2_q};
    dist_sum = {2'd0, pr[25:8]} + {2'd0, dg2_q, 2'b00} + {2'd0, pb[25:8]};
    near     = en_i && (dist_sum <= limit_sq_i);
    tok_d    = s1_tok_q;
    tok_d.hit = s1_tok_q.hit | near;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* rtl/color_palette_learn_and_match_core.sv */
// result: valid once the token of the accepted item has left the last cell
// no new item is taken while a token is in the row, a pace set by the color token
//   walking the row of cells at two register stages per cell
// reset: entry count zero, distance limit 30, no result pending;
//   palette entries hold no reset value and are read only below the count
module color_palette_learn_and_match_core import cplm_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cplm_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cplm_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);

  logic                in_acc;
  logic                busy_q;
  logic                op_q, start_q;
  logic [ColorW-1:0]   color_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [LimitSqW-1:0] limit_sq_q;
  logic                out_valid_q;
  cplm_out_t           out_q, out_d;
  logic                done, not_full, add;
  logic [PALETTE_DEPTH-1:0] cell_en, cell_wr;
  cplm_tok_t           tok [0:PALETTE_DEPTH];

  // take an item only when the row is idle and the result slot is free
  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign in_acc     = in_valid_i & ~in_stall_o;

  // token entering the row
  assign tok[0] = '{valid: in_acc, color: in_data_i.pixel_color, hit: 1'b0};

  // row of compare cells
  for (genvar gi = 0; gi < PALETTE_DEPTH; gi++) begin : g_cell
    assign cell_en[gi] = count_q > CntW'(gi);
    assign cell_wr[gi] = add && (count_q == CntW'(gi));

    cplm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok[gi]),
      .tok_o      (tok[gi+1]),
      .en_i       (cell_en[gi]),
      .wr_en_i    (cell_wr[gi]),
      .wr_color_i (color_q),
      .limit_sq_i (limit_sq_q)
    );
  end

  // result once the token leaves the last cell
  always_comb begin
    done     = tok[PALETTE_DEPTH].valid;
    not_full = count_q < CntW'(PALETTE_DEPTH);
    add      = done && (op_q == OpLearn) && not_full &&
               (start_q || !tok[PALETTE_DEPTH].hit);
    count_d  = add ? (count_q + CntW'(1)) : count_q;
    out_d.matched      = (op_q == OpMatch) && tok[PALETTE_DEPTH].hit;
    out_d.added        = add;
    out_d.palette_full = count_d >= CntW'(PALETTE_DEPTH);
    out_d.entry_count  = CountW'(count_d);
  end

  // control, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OpLearn;
      start_q     <= 1'b0;
      color_q     <= '0;
      out_q       <= '0;
    end else begin
      if (in_acc) begin
        busy_q  <= 1'b1;
        op_q    <= in_data_i.operation;
        start_q <= in_data_i.batch_start;
        color_q <= in_data_i.pixel_color;
      end else if (done) begin
        busy_q  <= 1'b0;
      end
      if (done) begin
        count_q     <= count_d;
        out_q       <= out_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // limit register kept squared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_sq_q <= LimitSqReset;
    end else if (cfg_we_i) begin
      limit_sq_q <= {10'd0, cfg_wdata_i} * {10'd0, cfg_wdata_i};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/cplm_sva.sv */
`include "color_palette_learn_and_match_core_macros.svh"

module cplm_sva import cplm_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input cplm_out_t out_data_o
);

  // a pending result is held until taken
  `CPLM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // an accepted item keeps the row busy for the next cycle
  `CPLM_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // an item never both matches and adds
  `CPLM_ASSERT_NOW(a_match_or_add, out_valid_o, !(out_data_o.matched && out_data_o.added))

  // full flag agrees with the reported count
  `CPLM_ASSERT_NOW(a_full_count, out_valid_o && out_data_o.palette_full,
                   out_data_o.entry_count == CountW'(PALETTE_DEPTH))

endmodule

bind color_palette_learn_and_match_core cplm_sva #(
  .PALETTE_DEPTH(PALETTE_DEPTH)
) u_cplm_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
